FILE: rtl/core/camera_view_matrix_orthonormalize_unit_defines.svh
// Shared assertion macros for the view-matrix orthonormalizer.
`ifndef CAMERA_VIEW_MATRIX_ORTHONORMALIZE_UNIT_DEFINES_SVH
`define CAMERA_VIEW_MATRIX_ORTHONORMALIZE_UNIT_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define CVMO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvmo check failed");

// Next-cycle implication, gated off during reset.
`define CVMO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvmo check failed");

`endif

FILE: rtl/core/cvmo_pkg.sv
package cvmo_pkg;

    // Field widths: basis Q2.14, position / translation Q16.16
    localparam int BW   = 16;
    localparam int PW   = 32;
    localparam int FRAC = BW - 2;

    // Cross product result width (exact difference of two products)
    localparam int CW = 2 * BW + 1;

    // Unit-vector datapath
    localparam int MAG_W      = CW - 1;
    localparam int NORM_STEPS = $clog2(MAG_W);
    localparam int SQR_W      = 2 * (MAG_W - 1);
    localparam int SUM_W      = SQR_W + 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int ROOT_W     = ROOT_STEPS + 1;
    localparam int QUO_W      = FRAC + 1;
    localparam int DIV_W      = (MAG_W - 1) + QUO_W + 2;

    // Sideband carried beside a vector: one basis plus the position
    localparam int SIDE_W = 3 * PW + 3 * BW;
    localparam int DATA_W = 9 * BW + 3 * PW;

    typedef struct packed {
        logic [2:0][PW-1:0] pos;
        logic [2:0][BW-1:0] axis;
    } t_side;

    // Stage control shared by every pipeline section
    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

endpackage

FILE: rtl/core/cvmo_unit.sv
module cvmo_unit #(
    parameter int SW = cvmo_pkg::SIDE_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cvmo_pkg::t_stage_ctl             i_ctl,
    input  logic [2:0][cvmo_pkg::CW-1:0]     i_vec,
    input  logic [SW-1:0]                    i_side,
    output logic                             o_vld,
    output logic [2:0][cvmo_pkg::BW-1:0]     o_unit,
    output logic [SW-1:0]                    o_side
);
    import cvmo_pkg::*;

    // ---------------- stage A: magnitude, sign, max ----------------
    logic [2:0][MAG_W-1:0] a_mag;
    logic [2:0]            a_neg;
    logic [MAG_W-1:0]      a_mx;

    always_comb begin
        logic [CW-1:0] v;
        a_mx = '0;
        for (int i = 0; i < 3; i++) begin
            v        = i_vec[i];
            a_neg[i] = v[CW-1];
            v        = a_neg[i] ? (~v + 1'b1) : v;
            a_mag[i] = v[MAG_W-1:0];
            if (a_mag[i] > a_mx) begin
                a_mx = a_mag[i];
            end
        end
    end

    // ---------------- normalize: max into [2^30, 2^31) ----------------
    logic [MAG_W-1:0]      r_nm_mx   [0:NORM_STEPS];
    logic [2:0][MAG_W-1:0] r_nm_mag  [0:NORM_STEPS];
    logic [2:0]            r_nm_neg  [0:NORM_STEPS];
    logic [SW-1:0]         r_nm_side [0:NORM_STEPS];
    logic [NORM_STEPS:0]   r_nm_vld;
    logic [MAG_W-1:0]      n_nm_mx   [1:NORM_STEPS];
    logic [2:0][MAG_W-1:0] n_nm_mag  [1:NORM_STEPS];

    always_comb begin
        int sh;
        for (int s = 0; s < NORM_STEPS; s++) begin
            sh            = 1 << (NORM_STEPS - 1 - s);
            n_nm_mx[s+1]  = r_nm_mx[s];
            n_nm_mag[s+1] = r_nm_mag[s];
            if (s == 0 && r_nm_mx[s][MAG_W-1]) begin
                // too large by one bit: drop the lsb
                n_nm_mx[s+1] = r_nm_mx[s] >> 1;
                for (int i = 0; i < 3; i++) begin
                    n_nm_mag[s+1][i] = r_nm_mag[s][i] >> 1;
                end
            end else if (r_nm_mx[s] < (MAG_W'(1) << (MAG_W - 1 - sh))) begin
                n_nm_mx[s+1] = r_nm_mx[s] << sh;
                for (int i = 0; i < 3; i++) begin
                    n_nm_mag[s+1][i] = r_nm_mag[s][i] << sh;
                end
            end
        end
    end

    // ---------------- squares ----------------
    logic [2:0][SQR_W-1:0]   r_sq_sq;
    logic [2:0][MAG_W-2:0]   r_sq_mag;
    logic [2:0]              r_sq_neg;
    logic                    r_sq_zero;
    logic [SW-1:0]           r_sq_side;
    logic                    r_sq_vld;
    logic [2:0][SQR_W-1:0]   n_sq_sq;

    always_comb begin
        logic [SQR_W-1:0] m;
        for (int i = 0; i < 3; i++) begin
            m          = SQR_W'(r_nm_mag[NORM_STEPS][i][MAG_W-2:0]);
            n_sq_sq[i] = m * m;
        end
    end

    // ---------------- sum and integer square root ----------------
    logic [SUM_W-1:0]      r_rt_v    [0:ROOT_STEPS];
    logic [SUM_W-1:0]      r_rt_r    [0:ROOT_STEPS];
    logic [2:0][MAG_W-2:0] r_rt_mag  [0:ROOT_STEPS];
    logic [2:0]            r_rt_neg  [0:ROOT_STEPS];
    logic                  r_rt_zero [0:ROOT_STEPS];
    logic [SW-1:0]         r_rt_side [0:ROOT_STEPS];
    logic [ROOT_STEPS:0]   r_rt_vld;
    logic [SUM_W-1:0]      n_rt_v    [1:ROOT_STEPS];
    logic [SUM_W-1:0]      n_rt_r    [1:ROOT_STEPS];

    // one result bit per stage
    always_comb begin
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] t;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            b = SUM_W'(1) << (SUM_W - 2 - 2 * k);
            t = r_rt_r[k] + b;
            if (r_rt_v[k] >= t) begin
                n_rt_v[k+1] = r_rt_v[k] - t;
                n_rt_r[k+1] = (r_rt_r[k] >> 1) + b;
            end else begin
                n_rt_v[k+1] = r_rt_v[k];
                n_rt_r[k+1] = r_rt_r[k] >> 1;
            end
        end
    end

    // ---------------- restoring divide: (mag*2^15 + n) / 2n ----------------
    logic [2:0][DIV_W-1:0] r_dv_rem  [0:QUO_W];
    logic [2:0][QUO_W-1:0] r_dv_q    [0:QUO_W];
    logic [ROOT_W-1:0]     r_dv_n    [0:QUO_W];
    logic [2:0]            r_dv_neg  [0:QUO_W];
    logic                  r_dv_zero [0:QUO_W];
    logic [SW-1:0]         r_dv_side [0:QUO_W];
    logic [QUO_W:0]        r_dv_vld;
    logic [2:0][DIV_W-1:0] n_dv_rem  [1:QUO_W];
    logic [2:0][QUO_W-1:0] n_dv_q    [1:QUO_W];
    logic [2:0][DIV_W-1:0] n_dv_num;
    logic [ROOT_W-1:0]     w_root;

    assign w_root = r_rt_r[ROOT_STEPS][ROOT_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dv_num[i] = DIV_W'({r_rt_mag[ROOT_STEPS][i], QUO_W'(0)}) + DIV_W'(w_root);
        end
    end

    always_comb begin
        logic [DIV_W-1:0] t;
        int bp;
        for (int j = 0; j < QUO_W; j++) begin
            bp = QUO_W - 1 - j;
            t  = DIV_W'(r_dv_n[j]) << (bp + 1);
            for (int i = 0; i < 3; i++) begin
                n_dv_rem[j+1][i] = r_dv_rem[j][i];
                n_dv_q[j+1][i]   = r_dv_q[j][i];
                if (r_dv_rem[j][i] >= t) begin
                    n_dv_rem[j+1][i]   = r_dv_rem[j][i] - t;
                    n_dv_q[j+1][i][bp] = 1'b1;
                end
            end
        end
    end

    // ---------------- sign restore ----------------
    logic [2:0][BW-1:0] r_o_unit;
    logic [SW-1:0]      r_o_side;
    logic               r_o_vld;
    logic [2:0][BW-1:0] n_o_unit;

    always_comb begin
        logic [BW-1:0] qe;
        for (int i = 0; i < 3; i++) begin
            qe = BW'(r_dv_q[QUO_W][i]);
            if (r_dv_zero[QUO_W]) begin
                n_o_unit[i] = '0;
            end else begin
                n_o_unit[i] = r_dv_neg[QUO_W][i] ? (~qe + 1'b1) : qe;
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_vld <= '0;
            r_sq_vld <= 1'b0;
            r_rt_vld <= '0;
            r_dv_vld <= '0;
            r_o_vld  <= 1'b0;
        end else if (i_ctl.en) begin
            r_nm_vld <= {r_nm_vld[NORM_STEPS-1:0], i_ctl.vld};
            r_sq_vld <= r_nm_vld[NORM_STEPS];
            r_rt_vld <= {r_rt_vld[ROOT_STEPS-1:0], r_sq_vld};
            r_dv_vld <= {r_dv_vld[QUO_W-1:0], r_rt_vld[ROOT_STEPS]};
            r_o_vld  <= r_dv_vld[QUO_W];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_nm_mx[0]   <= a_mx;
            r_nm_mag[0]  <= a_mag;
            r_nm_neg[0]  <= a_neg;
            r_nm_side[0] <= i_side;
            for (int s = 1; s <= NORM_STEPS; s++) begin
                r_nm_mx[s]   <= n_nm_mx[s];
                r_nm_mag[s]  <= n_nm_mag[s];
                r_nm_neg[s]  <= r_nm_neg[s-1];
                r_nm_side[s] <= r_nm_side[s-1];
            end

            r_sq_sq   <= n_sq_sq;
            for (int i = 0; i < 3; i++) begin
                r_sq_mag[i] <= r_nm_mag[NORM_STEPS][i][MAG_W-2:0];
            end
            r_sq_neg  <= r_nm_neg[NORM_STEPS];
            r_sq_zero <= !r_nm_mx[NORM_STEPS][MAG_W-2];
            r_sq_side <= r_nm_side[NORM_STEPS];

            r_rt_v[0]    <= SUM_W'(r_sq_sq[0]) + SUM_W'(r_sq_sq[1]) + SUM_W'(r_sq_sq[2]);
            r_rt_r[0]    <= '0;
            r_rt_mag[0]  <= r_sq_mag;
            r_rt_neg[0]  <= r_sq_neg;
            r_rt_zero[0] <= r_sq_zero;
            r_rt_side[0] <= r_sq_side;
            for (int k = 1; k <= ROOT_STEPS; k++) begin
                r_rt_v[k]    <= n_rt_v[k];
                r_rt_r[k]    <= n_rt_r[k];
                r_rt_mag[k]  <= r_rt_mag[k-1];
                r_rt_neg[k]  <= r_rt_neg[k-1];
                r_rt_zero[k] <= r_rt_zero[k-1];
                r_rt_side[k] <= r_rt_side[k-1];
            end

            r_dv_rem[0]  <= n_dv_num;
            r_dv_q[0]    <= '0;
            r_dv_n[0]    <= w_root;
            r_dv_neg[0]  <= r_rt_neg[ROOT_STEPS];
            r_dv_zero[0] <= r_rt_zero[ROOT_STEPS];
            r_dv_side[0] <= r_rt_side[ROOT_STEPS];
            for (int j = 1; j <= QUO_W; j++) begin
                r_dv_rem[j]  <= n_dv_rem[j];
                r_dv_q[j]    <= n_dv_q[j];
                r_dv_n[j]    <= r_dv_n[j-1];
                r_dv_neg[j]  <= r_dv_neg[j-1];
                r_dv_zero[j] <= r_dv_zero[j-1];
                r_dv_side[j] <= r_dv_side[j-1];
            end

            r_o_unit <= n_o_unit;
            r_o_side <= r_dv_side[QUO_W];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_unit = r_o_unit;
    assign o_side = r_o_side;

endmodule

FILE: rtl/core/cvmo_cross.sv
module cvmo_cross #(
    parameter int SW = cvmo_pkg::SIDE_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cvmo_pkg::t_stage_ctl             i_ctl,
    input  logic [2:0][cvmo_pkg::BW-1:0]     i_a,
    input  logic [2:0][cvmo_pkg::BW-1:0]     i_b,
    input  logic [SW-1:0]                    i_side,
    output logic                             o_vld,
    output logic [2:0][cvmo_pkg::CW-1:0]     o_vec,
    output logic [SW-1:0]                    o_side
);
    import cvmo_pkg::*;

    localparam int PRW = 2 * BW;

    logic [5:0][PRW-1:0] n_prod;
    logic [5:0][PRW-1:0] r_prod;
    logic [SW-1:0]       r_p_side;
    logic [2:0][CW-1:0]  n_vec;
    logic [2:0][CW-1:0]  r_vec;
    logic [SW-1:0]       r_c_side;
    logic [1:0]          r_vld;

    // six signed products
    always_comb begin
        logic signed [PRW-1:0] ea [0:2];
        logic signed [PRW-1:0] eb [0:2];
        for (int i = 0; i < 3; i++) begin
            ea[i] = $signed(i_a[i]);
            eb[i] = $signed(i_b[i]);
        end
        n_prod[0] = ea[1] * eb[2];
        n_prod[1] = ea[2] * eb[1];
        n_prod[2] = ea[2] * eb[0];
        n_prod[3] = ea[0] * eb[2];
        n_prod[4] = ea[0] * eb[1];
        n_prod[5] = ea[1] * eb[0];
    end

    // exact differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vec[i] = {r_prod[2*i][PRW-1], r_prod[2*i]}
                     - {r_prod[2*i+1][PRW-1], r_prod[2*i+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod   <= n_prod;
            r_p_side <= i_side;
            r_vec    <= n_vec;
            r_c_side <= r_p_side;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_vec  = r_vec;
    assign o_side = r_c_side;

endmodule

FILE: rtl/core/cvmo_xlat.sv
module cvmo_xlat (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cvmo_pkg::t_stage_ctl             i_ctl,
    input  logic [2:0][cvmo_pkg::CW-1:0]     i_cross,
    input  logic [2:0][cvmo_pkg::BW-1:0]     i_up,
    input  logic [2:0][cvmo_pkg::BW-1:0]     i_look,
    input  logic [2:0][cvmo_pkg::PW-1:0]     i_pos,
    output logic                             o_vld,
    output logic [2:0][cvmo_pkg::BW-1:0]     o_right,
    output logic [2:0][cvmo_pkg::BW-1:0]     o_up,
    output logic [2:0][cvmo_pkg::BW-1:0]     o_look,
    output logic [2:0][cvmo_pkg::PW-1:0]     o_trans
);
    import cvmo_pkg::*;

    localparam int PRW = PW + BW;
    localparam int DTW = PRW + 2;

    // Q5.28 -> Q2.14, nearest with ties away from zero, clamped
    function automatic logic [BW-1:0] round_basis(input logic [CW-1:0] v);
        logic          neg;
        logic [CW-1:0] mag;
        logic [CW-1:0] rq;
        logic [BW-1:0] res;
        neg = v[CW-1];
        mag = neg ? (~v + 1'b1) : v;
        rq  = (mag + (CW'(1) << (FRAC - 1))) >> FRAC;
        if (!neg) begin
            res = (rq > ((CW'(1) << (BW - 1)) - 1'b1)) ? {1'b0, {(BW-1){1'b1}}} : rq[BW-1:0];
        end else begin
            res = (rq > (CW'(1) << (BW - 1))) ? {1'b1, {(BW-1){1'b0}}}
                                               : (~rq[BW-1:0] + 1'b1);
        end
        return res;
    endfunction

    // -(dot) from Q20.30 to Q16.16, nearest with ties away from zero, saturated
    function automatic logic [PW-1:0] neg_round_sat(input logic [DTW-1:0] d);
        logic           pos_out;
        logic [DTW-1:0] mag;
        logic [DTW-1:0] rq;
        logic [PW-1:0]  res;
        pos_out = d[DTW-1];
        mag     = pos_out ? (~d + 1'b1) : d;
        rq      = (mag + (DTW'(1) << (FRAC - 1))) >> FRAC;
        if (pos_out) begin
            res = (rq > ((DTW'(1) << (PW - 1)) - 1'b1)) ? {1'b0, {(PW-1){1'b1}}}
                                                          : rq[PW-1:0];
        end else begin
            res = (rq > (DTW'(1) << (PW - 1))) ? {1'b1, {(PW-1){1'b0}}}
                                                : (~rq[PW-1:0] + 1'b1);
        end
        return res;
    endfunction

    logic [3:0]                r_vld;
    logic [2:0][BW-1:0]        r_bas [1:4][0:2];
    logic [2:0][PW-1:0]        r_s1_pos;
    logic [2:0][2:0][PRW-1:0]  r_s3_prod;
    logic [2:0][DTW-1:0]       r_s4_dot;
    logic [2:0][PW-1:0]        r_s5_tr;
    logic [2:0][BW-1:0]        n_rn;
    logic [2:0][2:0][PRW-1:0]  n_prod;
    logic [2:0][DTW-1:0]       n_dot;
    logic [2:0][PW-1:0]        n_tr;

    // stage 1: round the second cross product into new right
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rn[i] = round_basis(i_cross[i]);
        end
    end

    // stage 2: position times each axis
    always_comb begin
        logic signed [PRW-1:0] ep;
        logic signed [PRW-1:0] ea;
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
                ep           = $signed(r_s1_pos[i]);
                ea           = $signed(r_bas[1][a][i]);
                n_prod[a][i] = ep * ea;
            end
        end
    end

    // stage 3: dot sums
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_dot[a] = {{2{r_s3_prod[a][0][PRW-1]}}, r_s3_prod[a][0]}
                     + {{2{r_s3_prod[a][1][PRW-1]}}, r_s3_prod[a][1]}
                     + {{2{r_s3_prod[a][2][PRW-1]}}, r_s3_prod[a][2]};
        end
    end

    // stage 4: negate, round, saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_tr[a] = neg_round_sat(r_s4_dot[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_bas[1][0] <= n_rn;
            r_bas[1][1] <= i_up;
            r_bas[1][2] <= i_look;
            r_s1_pos    <= i_pos;
            for (int s = 2; s <= 4; s++) begin
                r_bas[s] <= r_bas[s-1];
            end
            r_s3_prod <= n_prod;
            r_s4_dot  <= n_dot;
            r_s5_tr   <= n_tr;
        end
    end

    assign o_vld   = r_vld[3];
    assign o_right = r_bas[4][0];
    assign o_up    = r_bas[4][1];
    assign o_look  = r_bas[4][2];
    assign o_trans = r_s5_tr;

endmodule

FILE: rtl/core/camera_view_matrix_orthonormalize_unit.sv
// View-basis re-orthonormalizer.
// Slave stream: one camera per request (right, up, look axes in Q2.14 and
// position in Q16.16); the incoming up axis does not affect the result.
// Master stream: orthonormal right, up and look axes in Q2.14 and the view
// translation -(pos . axis) in Q16.16, saturated.
// Both tdata buses carry the fields back to back from bit 0 in the order
// listed in the port comments; 240 bits each.
// Throughput: one request per cycle while the output is not stalled, fully
// pipelined. The two 57-stage unit-vector sections (32-stage square root,
// 15-stage divider) set the depth.
// Reset clears every valid bit; payload registers are not reset.
// Output stall: a two-entry output stage (register plus skid) absorbs the
// result in flight; once the skid entry fills, the whole pipeline freezes
// and s_axis_tready drops until the master side drains it.
`include "camera_view_matrix_orthonormalize_unit_defines.svh"

module camera_view_matrix_orthonormalize_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // right_x,y,z, up_x,y,z, look_x,y,z (16b each), pos_x,y,z (32b each)
    input  logic [cvmo_pkg::DATA_W-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // new_right_x,y,z, new_up_x,y,z, new_look_x,y,z (16b), trans_x,y,z (32b)
    output logic [cvmo_pkg::DATA_W-1:0]   o_m_axis_tdata
);
    import cvmo_pkg::*;

    // input unpack
    logic [2:0][BW-1:0] w_right;
    logic [2:0][BW-1:0] w_look;
    logic [2:0][PW-1:0] w_pos;
    logic [2:0][CW-1:0] w_look_ext;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_right[i]    = i_s_axis_tdata[i*BW +: BW];
            w_look[i]     = i_s_axis_tdata[(6+i)*BW +: BW];
            w_pos[i]      = i_s_axis_tdata[9*BW + i*PW +: PW];
            w_look_ext[i] = {{(CW-BW){w_look[i][BW-1]}}, w_look[i]};
        end
    end

    // pipeline advance
    logic       w_en;
    logic       r_skd_vld;
    t_stage_ctl w_ctl_in;

    assign w_en            = !r_skd_vld;
    assign o_s_axis_tready = w_en;
    assign w_ctl_in        = '{en: w_en, vld: i_s_axis_tvalid};

    // look normalization
    logic               w_u1_vld;
    logic [2:0][BW-1:0] w_ln;
    t_side              w_u1_side;

    cvmo_unit #(.SW(SIDE_W)) u_unit_look (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_vec   (w_look_ext),
        .i_side  (t_side'{pos: w_pos, axis: w_right}),
        .o_vld   (w_u1_vld),
        .o_unit  (w_ln),
        .o_side  (w_u1_side)
    );

    // look x right
    logic               w_c1_vld;
    logic [2:0][CW-1:0] w_c1;
    t_side              w_c1_side;

    cvmo_cross #(.SW(SIDE_W)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, vld: w_u1_vld}),
        .i_a     (w_ln),
        .i_b     (w_u1_side.axis),
        .i_side  (t_side'{pos: w_u1_side.pos, axis: w_ln}),
        .o_vld   (w_c1_vld),
        .o_vec   (w_c1),
        .o_side  (w_c1_side)
    );

    // up normalization
    logic               w_u2_vld;
    logic [2:0][BW-1:0] w_un;
    t_side              w_u2_side;

    cvmo_unit #(.SW(SIDE_W)) u_unit_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, vld: w_c1_vld}),
        .i_vec   (w_c1),
        .i_side  (w_c1_side),
        .o_vld   (w_u2_vld),
        .o_unit  (w_un),
        .o_side  (w_u2_side)
    );

    // up x look
    logic               w_c2_vld;
    logic [2:0][CW-1:0] w_c2;
    logic [SIDE_W+3*BW-1:0] w_c2_side;
    t_side              w_c2_pl;
    logic [2:0][BW-1:0] w_c2_up;

    cvmo_cross #(.SW(SIDE_W + 3 * BW)) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, vld: w_u2_vld}),
        .i_a     (w_un),
        .i_b     (w_u2_side.axis),
        .i_side  ({w_u2_side, w_un}),
        .o_vld   (w_c2_vld),
        .o_vec   (w_c2),
        .o_side  (w_c2_side)
    );

    assign w_c2_pl = t_side'(w_c2_side[3*BW +: SIDE_W]);
    assign w_c2_up = w_c2_side[0 +: 3*BW];

    // rounding and translation
    logic               w_p_vld;
    logic [2:0][BW-1:0] w_p_right;
    logic [2:0][BW-1:0] w_p_up;
    logic [2:0][BW-1:0] w_p_look;
    logic [2:0][PW-1:0] w_p_tr;
    logic [DATA_W-1:0]  w_p_data;

    cvmo_xlat u_xlat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, vld: w_c2_vld}),
        .i_cross (w_c2),
        .i_up    (w_c2_up),
        .i_look  (w_c2_pl.axis),
        .i_pos   (w_c2_pl.pos),
        .o_vld   (w_p_vld),
        .o_right (w_p_right),
        .o_up    (w_p_up),
        .o_look  (w_p_look),
        .o_trans (w_p_tr)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_p_data[i*BW +: BW]           = w_p_right[i];
            w_p_data[(3+i)*BW +: BW]       = w_p_up[i];
            w_p_data[(6+i)*BW +: BW]       = w_p_look[i];
            w_p_data[9*BW + i*PW +: PW]    = w_p_tr[i];
        end
    end

    // output register plus skid entry
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] r_skd_data;
    logic              n_out_vld;
    logic              n_skd_vld;
    logic              w_out_load;
    logic              w_skd_load;
    logic              w_out_from_skd;

    always_comb begin
        n_out_vld      = r_out_vld;
        n_skd_vld      = r_skd_vld;
        w_out_load     = 1'b0;
        w_skd_load     = 1'b0;
        w_out_from_skd = 1'b0;
        if (r_skd_vld) begin
            if (i_m_axis_tready) begin
                w_out_from_skd = 1'b1;
                n_out_vld      = 1'b1;
                n_skd_vld      = 1'b0;
            end
        end else if (w_p_vld) begin
            if (!r_out_vld || i_m_axis_tready) begin
                w_out_load = 1'b1;
                n_out_vld  = 1'b1;
            end else begin
                w_skd_load = 1'b1;
                n_skd_vld  = 1'b1;
            end
        end else if (i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skd) begin
            r_out_data <= r_skd_data;
        end else if (w_out_load) begin
            r_out_data <= w_p_data;
        end
        if (w_skd_load) begin
            r_skd_data <= w_p_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    `CVMO_ASSERT_SAME(a_skid_behind_head, i_clk, i_rst_n, r_skd_vld, r_out_vld)
    `CVMO_ASSERT_NEXT(a_frozen_pipe_holds, i_clk, i_rst_n, r_skd_vld && w_p_vld && !i_m_axis_tready, w_p_vld && $stable(w_p_data))
    `CVMO_ASSERT_SAME(a_zero_look_all_zero, i_clk, i_rst_n, r_out_vld && (r_out_data[6*BW +: 3*BW] == '0), (r_out_data[0 +: 6*BW] == '0) && (r_out_data[9*BW +: 3*PW] == '0))

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import cvmo_pkg::*;

    localparam int LATENCY     = 122;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1250;

    typedef logic [DATA_W-1:0] t_word;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_s_axis_tvalid;
    logic  o_s_axis_tready;
    t_word i_s_axis_tdata;   // right xyz, up xyz, look xyz (16b), pos xyz (32b)
    logic  o_m_axis_tvalid;
    logic  i_m_axis_tready;
    t_word o_m_axis_tdata;   // new right xyz, new up xyz, new look xyz (16b), trans xyz (32b)

    camera_view_matrix_orthonormalize_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_word  camera_q[$];     // requests waiting to be driven
    t_word  basis_q[$];      // predicted view bases in flight
    int     errors    = 0;
    int     cycles    = 0;
    int     n_results = 0;
    int     n_sent    = 0;
    bit     hold_send = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round v / 2^sh to nearest, ties away from zero
    function automatic longint round_shift(longint v, int sh);
        longint half;
        half = longint'(1) << (sh - 1);
        if (v < 0) return -((-v + half) >>> sh);
        return (v + half) >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Unit vector in Q2.14; components up to 2^31 in magnitude
    function automatic void normalize(input longint c[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned mx, sum, n, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            o = '{0, 0, 0};
            return;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        while (mx >= (64'd1 << 31)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + n) / (2 * n);
            o[i] = clip(c[i] < 0 ? -longint'(q) : longint'(q), -32768, 32767);
        end
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [PW-1:0] view_offset(longint p[3], longint a[3]);
        longint d;
        d = p[0] * a[0] + p[1] * a[1] + p[2] * a[2];
        return PW'(clip(round_shift(-d, 14), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic t_word predict_basis(t_word cam);
        longint rgt[3], lk[3], pos[3], lk_n[3], up_n[3], rt_n[3], tmp[3];
        t_word res;
        for (int i = 0; i < 3; i++) begin
            rgt[i] = longint'($signed(cam[i*BW +: BW]));
            lk[i]  = longint'($signed(cam[(6+i)*BW +: BW]));
            pos[i] = longint'($signed(cam[9*BW + i*PW +: PW]));
        end
        normalize(lk, lk_n);
        cross_vec(lk_n, rgt, tmp);
        normalize(tmp, up_n);
        cross_vec(up_n, lk_n, tmp);
        for (int i = 0; i < 3; i++) rt_n[i] = clip(round_shift(tmp[i], 14), -32768, 32767);
        res = '0;
        for (int i = 0; i < 3; i++) begin
            res[i*BW +: BW]     = BW'(rt_n[i]);
            res[(3+i)*BW +: BW] = BW'(up_n[i]);
            res[(6+i)*BW +: BW] = BW'(lk_n[i]);
        end
        res[9*BW +: PW]      = view_offset(pos, rt_n);
        res[9*BW + PW +: PW] = view_offset(pos, up_n);
        res[9*BW + 2*PW +: PW] = view_offset(pos, lk_n);
        return res;
    endfunction

    function automatic t_word pack_camera(logic [BW-1:0] ax[9], logic [PW-1:0] p[3]);
        t_word w;
        w = '0;
        for (int i = 0; i < 9; i++) w[i*BW +: BW] = ax[i];
        for (int i = 0; i < 3; i++) w[9*BW + i*PW +: PW] = p[i];
        return w;
    endfunction

    // Random axis component: mostly within the unit range, some tiny, sometimes anything
    function automatic logic [BW-1:0] rand_axis();
        case ($urandom_range(0, 3))
            0:       return BW'($urandom);
            1:       return BW'($urandom_range(0, 32) - 16);
            default: return BW'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [PW-1:0] rand_pos();
        case ($urandom_range(0, 2))
            0:       return PW'($urandom);
            1:       return PW'(int'($urandom_range(0, 200000)) - 100000);
            default: return PW'(int'($urandom_range(0, 2000000000)) - 1000000000);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [BW-1:0] ax[9];
        logic [PW-1:0] p[3];
        // extremes and special cases
        ax = '{default: 16'h7FFF}; p = '{default: 32'h7FFF_FFFF};
        camera_q.push_back(pack_camera(ax, p));
        ax = '{default: 16'h8000}; p = '{default: 32'h8000_0000};
        camera_q.push_back(pack_camera(ax, p));
        // zero-length look
        ax = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0};
        p = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        camera_q.push_back(pack_camera(ax, p));
        // look parallel to right
        ax = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'hC000, 16'h0, 16'h0};
        camera_q.push_back(pack_camera(ax, p));
        // canonical basis, unnormalized look
        ax = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0001};
        camera_q.push_back(pack_camera(ax, p));
        ax = '{16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h1234, 16'h7FFF};
        p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        camera_q.push_back(pack_camera(ax, p));
        ax = '{16'h8000, 16'h7FFF, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h8000, 16'h7FFF};
        camera_q.push_back(pack_camera(ax, p));
        ax = '{16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'h0001, 16'hFFFF, 16'h0001};
        p = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0};
        camera_q.push_back(pack_camera(ax, p));
        for (int k = 0; k < 8; k++) begin
            ax[0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            for (int i = 1; i < 9; i++) ax[i] = rand_axis();
            for (int i = 0; i < 3; i++) p[i] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            camera_q.push_back(pack_camera(ax, p));
        end
        // random cameras
        for (int k = 0; k < N_RANDOM; k++) begin
            for (int i = 0; i < 9; i++) ax[i] = rand_axis();
            for (int i = 0; i < 3; i++) p[i] = rand_pos();
            camera_q.push_back(pack_camera(ax, p));
        end
    end

    // Driver: random gaps, one pause that drains the pipeline
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            gap             <= $urandom_range(0, 19);
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                basis_q.push_back(predict_basis(i_s_axis_tdata));
                n_sent <= n_sent + 1;
                if (n_sent + 1 == 600) hold_send <= 1'b1;
            end
            if (hold_send && basis_q.size() == 0 && !i_s_axis_tvalid) hold_send <= 1'b0;
            if (gap > 0 || camera_q.size() == 0 || hold_send
                || (i_s_axis_tvalid && n_sent + 1 == 600)) begin
                i_s_axis_tvalid <= 1'b0;
                if (gap > 0) gap <= gap - 1;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= camera_q.pop_front();
                // long bursts without gaps while n_sent is between 300 and 500
                gap <= (n_sent > 300 && n_sent < 500) ? 0 : $urandom_range(0, 19);
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    int stall = 0;
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall           <= $urandom_range(0, 19);
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results <= n_results + 1;
                if (basis_q.size() == 0) begin
                    $error("result with nothing expected: %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    want = basis_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (want[i*BW +: BW] !== o_m_axis_tdata[i*BW +: BW]) begin
                            $error("%s_%s: expected %0d, got %0d",
                                   i < 3 ? "new_right" : (i < 6 ? "new_up" : "new_look"),
                                   i % 3 == 0 ? "x" : (i % 3 == 1 ? "y" : "z"),
                                   $signed(want[i*BW +: BW]),
                                   $signed(o_m_axis_tdata[i*BW +: BW]));
                            errors++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (want[9*BW + i*PW +: PW] !== o_m_axis_tdata[9*BW + i*PW +: PW]) begin
                            $error("trans_%s: expected %0d, got %0d",
                                   i == 0 ? "x" : (i == 1 ? "y" : "z"),
                                   $signed(want[9*BW + i*PW +: PW]),
                                   $signed(o_m_axis_tdata[9*BW + i*PW +: PW]));
                            errors++;
                        end
                end
            end
            // random back-pressure, none during the burst window
            if (stall > 0 && !(n_sent > 300 && n_sent < 500)) begin
                i_m_axis_tready <= 1'b0;
                stall           <= stall - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (o_m_axis_tvalid && i_m_axis_tready) stall <= $urandom_range(0, 19);
            end
        end
    end

    // Reset, watchdog and end of run
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (camera_q.size() != 0);
        while ((camera_q.size() != 0 || i_s_axis_tvalid || basis_q.size() != 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            $display("Checked %0d camera bases (extremes, zero and parallel look, random).",
                     n_results);
            if (errors == 0) $display("DONE: 0 errors");
            else $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
